/* rtl/hnod_pkg.sv */
// Shared types and constants for the HMM next-observation predictor.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package hnod_pkg;

    localparam int DEF_MAX_STATES = 16;
    localparam int DEF_MAX_OBS    = 16;

    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int OBS_W     = 4;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 6;  // covers up to 64 states or symbols

    localparam logic [VALUE_W-1:0] ONE_Q15 = 16'h8000;

    typedef enum logic [1:0] {
        ACT_LOAD_TRANS = 2'd0,
        ACT_LOAD_EMIS  = 2'd1,
        ACT_LOAD_INIT  = 2'd2,
        ACT_COMPUTE    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STATE_COUNT = 2'd0,
        REG_OBS_COUNT   = 2'd1
    } reg_index_t;

    // one multiply-accumulate step issued by the controller
    typedef struct packed {
        logic             valid;
        logic             phase2;    // 0: pi*A, 1: dist*B
        logic             first;     // i == 0
        logic             last;      // i == n-1
        logic             last_obs;  // final symbol of the run
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } cmd_t;

    typedef struct packed {
        logic busy;      // MAC pipeline holds a step
        logic out_full;  // result register holds a beat
    } stat_t;

endpackage

`default_nettype wire

/* rtl/hnod_if.sv */
// Channel interfaces: input items, result items and the register write port.
// Depends on hnod_pkg.
`default_nettype none

interface hnod_in_if;
    logic                            valid;
    logic                            ready;
    hnod_pkg::action_t               action;
    logic [hnod_pkg::ROW_W-1:0]      row;
    logic [hnod_pkg::COL_W-1:0]      col;
    logic [hnod_pkg::VALUE_W-1:0]    value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface hnod_out_if;
    logic                            valid;
    logic                            ready;
    logic [hnod_pkg::OBS_W-1:0]      obs_index;
    logic [hnod_pkg::VALUE_W-1:0]    probability;
    logic                            last;

    modport source (output valid, obs_index, probability, last, input ready);
    modport sink   (input valid, obs_index, probability, last, output ready);
endinterface

interface hnod_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hnod_pkg::CFG_IDX_W-1:0]  index;
    logic [hnod_pkg::CNT_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/hnod_ctrl.sv */
// Controller: count registers, input handshake and the MAC sequencing FSM.
// Depends on hnod_pkg.
`default_nettype none

module hnod_ctrl #(
    parameter int MAX_STATES       = hnod_pkg::DEF_MAX_STATES,
    parameter int MAX_OBSERVATIONS = hnod_pkg::DEF_MAX_OBS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  hnod_pkg::action_t               in_action,
    output logic                            in_ready,
    input  logic                            cfg_valid,
    input  logic [hnod_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hnod_pkg::CNT_W-1:0]      cfg_data,
    input  hnod_pkg::stat_t                 stat,
    output hnod_pkg::cmd_t                  cmd,
    output logic                            load_en
);
    import hnod_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int OW = $clog2(MAX_OBSERVATIONS);
    localparam int JW = (SW > OW) ? SW : OW;
    localparam int NW = $clog2(MAX_STATES + 1);
    localparam int KW = $clog2(MAX_OBSERVATIONS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC1,
        S_WAIT2,
        S_MAC2
    } state_t;

    state_t            state_reg, state_next;
    logic [SW-1:0]     i_reg, i_next;
    logic [JW-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]  n_cfg_reg, n_cfg_next;
    logic [CNT_W-1:0]  k_cfg_reg, k_cfg_next;
    logic [NW-1:0]     n_cnt;
    logic [KW-1:0]     k_cnt;
    logic              i_last, j_last_n, j_last_k;
    logic              accept;

    // zero means one, above the maximum means the maximum
    always_comb
    begin
        if (n_cfg_reg == '0)
            n_cnt = NW'(1);
        else if (int'(n_cfg_reg) > MAX_STATES)
            n_cnt = NW'(MAX_STATES);
        else
            n_cnt = NW'(n_cfg_reg);

        if (k_cfg_reg == '0)
            k_cnt = KW'(1);
        else if (int'(k_cfg_reg) > MAX_OBSERVATIONS)
            k_cnt = KW'(MAX_OBSERVATIONS);
        else
            k_cnt = KW'(k_cfg_reg);
    end

    assign i_last   = (int'(i_reg) == int'(n_cnt) - 1);
    assign j_last_n = (int'(j_reg) == int'(n_cnt) - 1);
    assign j_last_k = (int'(j_reg) == int'(k_cnt) - 1);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_en  = accept && (in_action != ACT_COMPUTE);

    always_comb
    begin
        cmd          = '0;
        cmd.valid    = (state_reg == S_MAC1) || (state_reg == S_MAC2);
        cmd.phase2   = (state_reg == S_MAC2);
        cmd.first    = (i_reg == '0);
        cmd.last     = i_last;
        cmd.last_obs = (state_reg == S_MAC2) && j_last_k;
        cmd.i        = IDX_W'(i_reg);
        cmd.j        = IDX_W'(j_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_cfg_next = n_cfg_reg;
        k_cfg_next = k_cfg_reg;

        if (cfg_valid)
        begin
            if (cfg_index == REG_STATE_COUNT)
                n_cfg_next = cfg_data;
            else if (cfg_index == REG_OBS_COUNT)
                k_cfg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_action == ACT_COMPUTE))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_MAC1;
                end
            end
            S_MAC1:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (j_last_n)
                    begin
                        j_next     = '0;
                        state_next = S_WAIT2;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            // state distribution written back and result register free
            S_WAIT2:
            begin
                if (!stat.busy && !stat.out_full)
                    state_next = S_MAC2;
            end
            S_MAC2:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (j_last_k)
                    begin
                        j_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_WAIT2;
                    end
                end
                else
                    i_next = i_reg + 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_cfg_reg <= CNT_W'(1);
            k_cfg_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_cfg_reg <= n_cfg_next;
            k_cfg_reg <= k_cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/hnod_datapath.sv */
// Datapath: the four stores, a three-stage multiply-accumulate pipeline
// and the result register. Depends on hnod_pkg.
`default_nettype none

module hnod_datapath #(
    parameter int MAX_STATES       = hnod_pkg::DEF_MAX_STATES,
    parameter int MAX_OBSERVATIONS = hnod_pkg::DEF_MAX_OBS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hnod_pkg::cmd_t                cmd,
    input  logic                          load_en,
    input  hnod_pkg::action_t             action,
    input  logic [hnod_pkg::ROW_W-1:0]    row,
    input  logic [hnod_pkg::COL_W-1:0]    col,
    input  logic [hnod_pkg::VALUE_W-1:0]  value,
    output hnod_pkg::stat_t               stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hnod_pkg::OBS_W-1:0]    obs_index,
    output logic [hnod_pkg::VALUE_W-1:0]  probability,
    output logic                          last
);
    import hnod_pkg::*;

    localparam int SW     = $clog2(MAX_STATES);
    localparam int OW     = $clog2(MAX_OBSERVATIONS);
    localparam int TDEPTH = MAX_STATES * MAX_STATES;
    localparam int EDEPTH = MAX_STATES * MAX_OBSERVATIONS;
    localparam int TA     = $clog2(TDEPTH);
    localparam int EA     = $clog2(EDEPTH);

    logic [VALUE_W-1:0] trans_mem [TDEPTH];
    logic [VALUE_W-1:0] emis_mem  [EDEPTH];
    logic [VALUE_W-1:0] init_mem  [MAX_STATES];
    logic [VALUE_W-1:0] dist_mem  [MAX_STATES];

    logic [VALUE_W-1:0] v_sat;
    logic               row_ok, col_s_ok, col_o_ok;
    logic               trans_we, emis_we, init_we;
    logic [TA-1:0]      trans_wa, trans_ra;
    logic [EA-1:0]      emis_wa, emis_ra;
    logic [SW-1:0]      init_wa, rd_i;

    logic [VALUE_W-1:0] trans_q_reg, emis_q_reg, init_q_reg, dist_q_reg;
    cmd_t               s1_reg, s2_reg;
    logic [VALUE_W-1:0] op_a, op_b;
    logic [2*VALUE_W-1:0] mult;
    logic [VALUE_W-1:0] prod_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W:0]   sum;
    logic [VALUE_W-1:0] sum_sat;
    logic               dist_we, res_we;

    logic               out_valid_reg;
    logic [OBS_W-1:0]   obs_index_reg;
    logic [VALUE_W-1:0] prob_reg;
    logic               last_reg;

    // load decode
    assign v_sat    = (value > ONE_Q15) ? ONE_Q15 : value;
    assign row_ok   = (int'(row) < MAX_STATES);
    assign col_s_ok = (int'(col) < MAX_STATES);
    assign col_o_ok = (int'(col) < MAX_OBSERVATIONS);
    assign trans_wa = TA'(int'(row) * MAX_STATES + int'(col));
    assign emis_wa  = EA'(int'(row) * MAX_OBSERVATIONS + int'(col));
    assign init_wa  = SW'(col);

    always_comb
    begin
        trans_we = 1'b0;
        emis_we  = 1'b0;
        init_we  = 1'b0;
        unique case (action)
            ACT_LOAD_TRANS: trans_we = load_en && row_ok && col_s_ok;
            ACT_LOAD_EMIS:  emis_we  = load_en && row_ok && col_o_ok;
            ACT_LOAD_INIT:  init_we  = load_en && col_s_ok;
            ACT_COMPUTE:    ;
            default:        ;
        endcase
    end

    // read addresses of the issued step
    assign rd_i     = cmd.i[SW-1:0];
    assign trans_ra = TA'(int'(cmd.i[SW-1:0]) * MAX_STATES + int'(cmd.j[SW-1:0]));
    assign emis_ra  = EA'(int'(cmd.i[SW-1:0]) * MAX_OBSERVATIONS + int'(cmd.j[OW-1:0]));

    always_ff @(posedge clk)
    begin
        if (trans_we)
            trans_mem[trans_wa] <= v_sat;
        trans_q_reg <= trans_mem[trans_ra];
    end

    always_ff @(posedge clk)
    begin
        if (emis_we)
            emis_mem[emis_wa] <= v_sat;
        emis_q_reg <= emis_mem[emis_ra];
    end

    always_ff @(posedge clk)
    begin
        if (init_we)
            init_mem[init_wa] <= v_sat;
        init_q_reg <= init_mem[rd_i];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[s2_reg.j[SW-1:0]] <= sum_sat;
        dist_q_reg <= dist_mem[rd_i];
    end

    // stage 2: Q1.15 product, truncated
    assign op_a = s1_reg.phase2 ? dist_q_reg : init_q_reg;
    assign op_b = s1_reg.phase2 ? emis_q_reg : trans_q_reg;
    assign mult = op_a * op_b;

    // stage 3: saturating accumulate
    assign sum     = (s2_reg.first ? (VALUE_W+1)'(0) : {1'b0, acc_reg}) + {1'b0, prod_reg};
    assign sum_sat = (sum > {1'b0, ONE_Q15}) ? ONE_Q15 : sum[VALUE_W-1:0];
    assign dist_we = s2_reg.valid && s2_reg.last && !s2_reg.phase2;
    assign res_we  = s2_reg.valid && s2_reg.last && s2_reg.phase2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= cmd;
            s2_reg <= s1_reg;
            if (res_we)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mult[VALUE_W+14:15];
        if (s2_reg.valid)
            acc_reg <= sum_sat;
        if (res_we)
        begin
            obs_index_reg <= OBS_W'(s2_reg.j);
            prob_reg      <= sum_sat;
            last_reg      <= s2_reg.last_obs;
        end
    end

    assign stat.busy     = s1_reg.valid || s2_reg.valid;
    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign obs_index     = obs_index_reg;
    assign probability   = prob_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

/* rtl/hmm_next_observation_distribution.sv */
// Top level of the HMM next-observation predictor: controller plus datapath.
// Depends on hnod_pkg, hnod_if, hnod_ctrl and hnod_datapath.
//
//   channel  direction  beat contents
//   items    in         action, row, col, value
//   results  out        obs_index, probability, last
//   cfg      in         index, data (state_count, observation_count)
//
// Load beats are taken one per cycle while no compute is running.
// A compute issues one MAC step per cycle within each column, set by the
// single read port of each store; each symbol's column starts only after
// the MAC pipeline has drained and the previous result beat left the
// result register.
// Reset clears control state only; stores hold garbage until loaded.
// A stalled result does not block load beats, only the next column.
`default_nettype none

module hmm_next_observation_distribution #(
    parameter int MAX_STATES       = hnod_pkg::DEF_MAX_STATES,
    parameter int MAX_OBSERVATIONS = hnod_pkg::DEF_MAX_OBS
) (
    input  logic        clk,
    input  logic        rst_n,
    hnod_in_if.sink     items,
    hnod_out_if.source  results,
    hnod_cfg_if.sink    cfg
);
    import hnod_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  load_en;

    assign cfg.ready = 1'b1;

    hnod_ctrl #(
        .MAX_STATES       (MAX_STATES),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_action (items.action),
        .in_ready  (items.ready),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .stat      (stat),
        .cmd       (cmd),
        .load_en   (load_en)
    );

    hnod_datapath #(
        .MAX_STATES       (MAX_STATES),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .load_en     (load_en),
        .action      (items.action),
        .row         (items.row),
        .col         (items.col),
        .value       (items.value),
        .stat        (stat),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .obs_index   (results.obs_index),
        .probability (results.probability),
        .last        (results.last)
    );

    // no input beat while a MAC step is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> !items.ready)
        else $error("input taken during compute");

    // a result column starts only with the result register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.phase2 && cmd.first |-> !results.valid)
        else $error("result column started over a pending beat");

    // a column's final step passes s1_reg and s2_reg, then its result beat is valid
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.phase2 && cmd.last |-> ##2 stat.busy ##1 results.valid)
        else $error("result beat missing after column");

endmodule

`default_nettype wire
